// File: sv/ssf_pkg.sv
package ssf_pkg;

    // Default size of the sensor table
    localparam int unsigned SSF_SENSORS = 16;

    // Temperatures in signed sixteenths of a degree
    localparam logic signed [11:0] NO_VALUE      = -12'sd2032;
    localparam logic signed [11:0] OFFLINE_BELOW = -12'sd1920;

    // Refresh limit register holds the interval already scaled to milliseconds
    localparam int unsigned        LIMIT_W       = 26;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 26'd30000000;
    localparam logic [7:0]         SLEW_RESET    = 8'd8;

    // Configuration register indexes
    localparam logic [0:0] CFG_REFRESH_INTERVAL = 1'b0;
    localparam logic [0:0] CFG_MAX_SLEW         = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OFFLINE = 2'd0,
        VERDICT_SPIKE   = 2'd1,
        VERDICT_SAME    = 2'd2,
        VERDICT_PUBLISH = 2'd3
    } ssf_verdict_t;

    // One entry of the per-sensor store
    typedef struct packed {
        logic signed [11:0] temperature;
        logic [31:0]        good_time;
    } ssf_entry_t;

    // Global refresh bookkeeping
    typedef struct packed {
        logic        pass_refresh;
        logic [31:0] last_time;
    } ssf_refresh_t;

endpackage

// File: sv/ssf_cfg.sv
module ssf_cfg
    import ssf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output logic [LIMIT_W-1:0] refresh_limit,
    output logic [7:0]         max_slew
);

    logic [LIMIT_W-1:0] limit_reg;
    logic [LIMIT_W-1:0] limit_next;
    logic [7:0]         slew_reg;
    logic [7:0]         slew_next;

    // Scale the interval to milliseconds once, at the write
    always_comb begin
        limit_next = limit_reg;
        slew_next  = slew_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_REFRESH_INTERVAL: limit_next = LIMIT_W'(cfg_wdata * 26'd1000);
                CFG_MAX_SLEW:         slew_next  = cfg_wdata[7:0];
                default:              limit_next = limit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            slew_reg  <= SLEW_RESET;
        end else begin
            limit_reg <= limit_next;
            slew_reg  <= slew_next;
        end
    end

    assign refresh_limit = limit_reg;
    assign max_slew      = slew_reg;

endmodule

// File: sv/ssf_store.sv
module ssf_store
    import ssf_pkg::*;
#(
    parameter int unsigned SENSORS = SSF_SENSORS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rd_en,
    input  logic [3:0] rd_index,
    input  logic       wr_en,
    input  logic [3:0] wr_index,
    input  ssf_entry_t wr_entry,
    output ssf_entry_t rd_entry
);

    localparam int unsigned AW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

    ssf_entry_t         mem [SENSORS];
    logic [SENSORS-1:0] valid_reg;

    logic [AW+3:0] rd_wide;
    logic [AW+3:0] wr_wide;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    ssf_entry_t mem_q_reg;
    ssf_entry_t fwd_q_reg;
    logic       valid_q_reg;
    logic       fwd_hit_reg;

    assign rd_wide = {{AW{1'b0}}, rd_index};
    assign wr_wide = {{AW{1'b0}}, wr_index};
    assign rd_addr = rd_wide[AW-1:0];
    assign wr_addr = wr_wide[AW-1:0];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            mem_q_reg   <= mem[rd_addr];
            valid_q_reg <= valid_reg[rd_addr];
            fwd_q_reg   <= wr_entry;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Catch a write landing on the same entry in the read cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_index == rd_index);
        end
    end

    // Resolve forwarded, stored or reset value
    always_comb begin
        if (fwd_hit_reg) begin
            rd_entry = fwd_q_reg;
        end else if (valid_q_reg) begin
            rd_entry = mem_q_reg;
        end else begin
            rd_entry.temperature = NO_VALUE;
            rd_entry.good_time   = '0;
        end
    end

endmodule

// File: sv/ssf_judge.sv
module ssf_judge
    import ssf_pkg::*;
(
    input  logic               cmd,
    input  logic               pass_start,
    input  logic signed [11:0] reading,
    input  logic [31:0]        now_ms,
    input  ssf_entry_t         entry,
    input  ssf_refresh_t       refresh,
    input  logic [LIMIT_W-1:0] refresh_limit,
    input  logic [7:0]         max_slew,
    output ssf_refresh_t       refresh_next,
    output ssf_verdict_t       verdict,
    output logic signed [11:0] stored_value,
    output logic               good
);

    logic [31:0]        since;
    logic               due;
    logic signed [12:0] diff;
    logic [12:0]        mag;
    logic [39:0]        change_scaled;
    logic [31:0]        elapsed;
    logic [39:0]        allowed;
    logic               offline;
    logic               spike;
    logic               publish;

    // Refresh check at pass start; the clear command zeroes the timer
    always_comb begin
        since        = now_ms - refresh.last_time;
        due          = (refresh.last_time == '0) ||
                       (since > {{(32-LIMIT_W){1'b0}}, refresh_limit});
        refresh_next = refresh;
        if (cmd) begin
            refresh_next.last_time = '0;
        end else if (pass_start) begin
            refresh_next.pass_refresh = due;
            if (due) begin
                refresh_next.last_time = now_ms;
            end
        end
    end

    // Slew test: |change| * 1000 against elapsed ms * slew
    always_comb begin
        diff          = {reading[11], reading} - {entry.temperature[11], entry.temperature};
        mag           = diff[12] ? 13'(~diff + 13'sd1) : 13'(diff);
        change_scaled = (40'(mag) << 10) - (40'(mag) << 4) - (40'(mag) << 3);
        elapsed       = now_ms - entry.good_time;
        allowed       = 40'(elapsed) * 40'(max_slew);
        offline       = reading < OFFLINE_BELOW;
        spike         = (entry.temperature != NO_VALUE) && (change_scaled > allowed);
        publish       = refresh_next.pass_refresh || (reading != entry.temperature);
    end

    // Pick verdict and value after this reading
    always_comb begin
        good         = 1'b0;
        stored_value = entry.temperature;
        if (offline) begin
            verdict = VERDICT_OFFLINE;
        end else if (spike) begin
            verdict = VERDICT_SPIKE;
        end else if (publish) begin
            verdict      = VERDICT_PUBLISH;
            good         = 1'b1;
            stored_value = reading;
        end else begin
            verdict = VERDICT_SAME;
            good    = 1'b1;
        end
    end

endmodule

// File: sv/sensor_slew_spike_filter_top.sv
// Channel   Dir  Port group              Contents
// --------  ---  ----------------------  ---------------------------------------------
// reading   in   s_tvalid/s_tready       tdata: sensor_index, reading, now_ms; tuser: cmd, pass_start
// verdict   out  m_tvalid/m_tready       tdata: sensor_id, verdict, stored_value; tuser: forced_refresh
// config    in   cfg_we                  cfg_index, cfg_wdata
//
// One beat per cycle sustained while the output is not stalled. A beat passes through the evaluate
// register, where the store entry read at acceptance is judged, then sits in the output register,
// which drives m_tvalid.
// A write to the entry read in the same cycle is forwarded.
// Reset is synchronous; the store needs no clearing pass, per-entry valid bits clear at once.
// A stalled output holds the evaluate register, and the input stalls only while both are full.
module sensor_slew_spike_filter_top
    import ssf_pkg::*;
#(
    parameter int unsigned SENSORS = SSF_SENSORS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [3:0] sensor_index, [15:4] reading, [47:16] now_ms
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] pass_start
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] sensor_id, [5:4] verdict, [17:6] stored_value, zero pad
    output logic [0:0]  m_tuser    // [0] forced_refresh
);

    logic [LIMIT_W-1:0] refresh_limit;
    logic [7:0]         max_slew;

    // Evaluate stage registers
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic               s1_pass_start_reg;
    logic [3:0]         s1_index_reg;
    logic signed [11:0] s1_reading_reg;
    logic [31:0]        s1_now_reg;

    ssf_refresh_t       refresh_reg;
    ssf_refresh_t       refresh_next;

    // Output registers
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [3:0]         m_id_reg;
    ssf_verdict_t       m_verdict_reg;
    logic signed [11:0] m_stored_reg;
    logic               m_forced_reg;

    logic               accept;
    logic               produce;
    logic               retire;
    logic               in_range;

    ssf_entry_t         entry;
    ssf_entry_t         wr_entry;
    logic               wr_en;
    ssf_verdict_t       verdict;
    logic signed [11:0] stored_value;
    logic               good;

    ssf_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .refresh_limit (refresh_limit),
        .max_slew      (max_slew)
    );

    // Handshake: the evaluate register empties into the output register
    assign in_range = 32'(s1_index_reg) < 32'(SENSORS);
    assign produce  = !s1_cmd_reg && in_range;
    assign retire   = s1_valid_reg && (!produce || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || retire;
    assign accept   = s_tvalid && s_tready;

    assign wr_en    = retire && produce && good;
    assign wr_entry = {stored_value, s1_now_reg};

    ssf_store #(
        .SENSORS (SENSORS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_index (s_tdata[3:0]),
        .wr_en    (wr_en),
        .wr_index (s1_index_reg),
        .wr_entry (wr_entry),
        .rd_entry (entry)
    );

    ssf_judge u_judge (
        .cmd           (s1_cmd_reg),
        .pass_start    (s1_pass_start_reg),
        .reading       (s1_reading_reg),
        .now_ms        (s1_now_reg),
        .entry         (entry),
        .refresh       (refresh_reg),
        .refresh_limit (refresh_limit),
        .max_slew      (max_slew),
        .refresh_next  (refresh_next),
        .verdict       (verdict),
        .stored_value  (stored_value),
        .good          (good)
    );

    // Load the evaluate stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg        <= s_tuser[0];
            s1_pass_start_reg <= s_tuser[1];
            s1_index_reg      <= s_tdata[3:0];
            s1_reading_reg    <= s_tdata[15:4];
            s1_now_reg        <= s_tdata[47:16];
        end
    end

    // Next output valid
    always_comb begin
        if (retire && produce) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            refresh_reg  <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (retire) begin
                s1_valid_reg <= 1'b0;
            end
            m_valid_reg <= m_valid_next;
            if (retire) begin
                refresh_reg <= refresh_next;
            end
        end
    end

    // Capture the result beat
    always_ff @(posedge aclk) begin
        if (retire && produce) begin
            m_id_reg      <= s1_index_reg;
            m_verdict_reg <= verdict;
            m_stored_reg  <= stored_value;
            m_forced_reg  <= refresh_next.pass_refresh;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_stored_reg, m_verdict_reg, m_id_reg};
    assign m_tuser  = m_forced_reg;

    // Clear command leaves the refresh timer at zero
    a_clear_zeroes_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && s1_cmd_reg) |=> (refresh_reg.last_time == '0))
        else $error("refresh timer not cleared by clear command");

    // A retiring reading always shows up on the output
    a_retire_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && produce) |=> m_valid_reg)
        else $error("retired reading lost");

    // A beat without result never raises a new output
    a_no_result_no_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (retire && !produce && m_valid_reg && m_tready) |=> !m_valid_reg)
        else $error("result invented for a beat without one");

    // A stalled evaluate stage holds its item
    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !retire) |=> (s1_valid_reg && $stable(s1_index_reg)
            && $stable(s1_now_reg)))
        else $error("evaluate stage changed while stalled");

    // Spike and offline verdicts never alter the store
    a_reject_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (verdict == VERDICT_SPIKE || verdict == VERDICT_OFFLINE)) |-> !wr_en)
        else $error("store written for a rejected reading");

endmodule
